// ----- src/icsq_pkg.sv -----
// ----------------------------------------------------------------------------
// icsq_pkg
// Shared types and constants for the igniter command sequencer.
// ----------------------------------------------------------------------------
package icsq_pkg;

  localparam int unsigned CfgW       = 20;
  localparam int unsigned FrameBytes = 4;
  localparam int unsigned StoreDepth = FrameBytes - 1;
  localparam int unsigned PosW       = $clog2(FrameBytes);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CmdHdr   = 8'hAA;
  localparam logic [7:0] AckHdr   = 8'hAB;
  localparam logic [7:0] OpIgn    = 8'h49;
  localparam logic [7:0] OpSpare  = 8'h53;
  localparam logic [7:0] OpTanks  = 8'h54;
  localparam logic [7:0] OpPilot  = 8'h50;
  localparam logic [7:0] ValOn    = 8'h01;
  localparam logic [7:0] ValOff   = 8'h02;

  localparam logic [CfgW-1:0] PilotDelayRst = 20'd5000;
  localparam logic [CfgW-1:0] BurnTimeRst   = 20'd10000;

  // configuration register indexes
  localparam logic RegPilotDelay = 1'b0;
  localparam logic RegBurnTime   = 1'b1;

  // output level bit positions
  localparam int unsigned LvIgn   = 0;
  localparam int unsigned LvPilot = 1;
  localparam int unsigned LvTanks = 2;
  localparam int unsigned LvSpare = 3;

  typedef enum logic {
    EV_TICK = 1'b0,
    EV_CMD  = 1'b1
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] op;
    logic       on;
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRING = 4'b0010,
    PH_PILOT  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

endpackage

// ----- src/icsq_req_if.sv -----
// ----------------------------------------------------------------------------
// icsq_req_if
// Request channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface icsq_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- src/icsq_ack_if.sv -----
// ----------------------------------------------------------------------------
// icsq_ack_if
// Acknowledge channel: one frame byte per transfer plus output levels.
// ----------------------------------------------------------------------------
interface icsq_ack_if;
  logic       valid;
  logic       ready;
  logic [7:0] ack_byte;
  logic       ack_last;
  logic       igniter_on;
  logic       pilot_on;
  logic       tanks_on;
  logic       spare_on;

  modport source (output valid, output ack_byte, output ack_last, output igniter_on,
                  output pilot_on, output tanks_on, output spare_on, input ready);
  modport sink   (input valid, input ack_byte, input ack_last, input igniter_on,
                  input pilot_on, input tanks_on, input spare_on, output ready);
endinterface

// ----- src/icsq_front.sv -----
// ----------------------------------------------------------------------------
// icsq_front
// Gathers command frames, checks header, XOR, op and value, classifies into events.
// ----------------------------------------------------------------------------
module icsq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  icsq_req_if.sink         req_i,
  input  logic             q_full_i,
  output logic             push_o,
  output icsq_pkg::event_t ev_o
);

  logic [icsq_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                store_q [icsq_pkg::StoreDepth];
  logic                      accept;
  logic                      frame_done;
  logic                      frame_ok;
  logic                      known_op;
  logic                      known_val;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign frame_done  = (pos_q == icsq_pkg::PosW'(icsq_pkg::FrameBytes - 1));

  always_comb begin
    frame_ok  = (store_q[0] == icsq_pkg::CmdHdr) &&
                ((store_q[0] ^ store_q[1] ^ store_q[2]) == req_i.rx_byte);
    known_op  = (store_q[1] == icsq_pkg::OpIgn)   || (store_q[1] == icsq_pkg::OpPilot) ||
                (store_q[1] == icsq_pkg::OpTanks) || (store_q[1] == icsq_pkg::OpSpare);
    known_val = (store_q[2] == icsq_pkg::ValOn) || (store_q[2] == icsq_pkg::ValOff);

    ev_o.kind = req_i.req_type ? icsq_pkg::EV_TICK : icsq_pkg::EV_CMD;
    ev_o.op   = store_q[1];
    ev_o.on   = (store_q[2] == icsq_pkg::ValOn);

    push_o = accept && (req_i.req_type || (frame_done && frame_ok && known_op && known_val));

    pos_d = pos_q;
    if (accept && !req_i.req_type) begin
      pos_d = frame_done ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !req_i.req_type && !frame_done) begin
      store_q[pos_q] <= req_i.rx_byte;
    end
  end

endmodule

// ----- src/icsq_queue.sv -----
// ----------------------------------------------------------------------------
// icsq_queue
// Small event queue between the frame front end and the sequencer.
// ----------------------------------------------------------------------------
module icsq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  icsq_pkg::event_t ev_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output icsq_pkg::event_t ev_o
);

  icsq_pkg::event_t                mem_q [icsq_pkg::QueueDepth];
  logic [icsq_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [icsq_pkg::QueueCntW-1:0]  cnt_q;
  logic                            do_pop;

  assign full_o  = (cnt_q == icsq_pkg::QueueCntW'(icsq_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign ev_o    = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == icsq_pkg::QueuePtrW'(icsq_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == icsq_pkg::QueuePtrW'(icsq_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

endmodule

// ----- src/icsq_back.sv -----
// ----------------------------------------------------------------------------
// icsq_back
// Executes events: output levels, timed firing sequence, acknowledge frames.
// ----------------------------------------------------------------------------
module icsq_back #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ev_valid_i,
  input  icsq_pkg::event_t          ev_i,
  output logic                      pop_o,
  input  logic [icsq_pkg::CfgW-1:0] pilot_delay_i,
  input  logic [icsq_pkg::CfgW-1:0] burn_time_i,
  icsq_ack_if.source                ack_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > icsq_pkg::CfgW) ? TIMER_WIDTH : icsq_pkg::CfgW;

  icsq_pkg::phase_e        phase_q, phase_d;
  logic [3:0]              lev_q, lev_d;
  logic [TIMER_WIDTH-1:0]  elapsed_q, elapsed_d, el_inc;
  logic                    busy_q, busy_d;
  logic [1:0]              beat_q, beat_d;
  logic [7:0]              aop_q, aop_d;
  logic                    alvl_q, alvl_d;
  logic                    last_beat;
  logic                    emit;
  logic [7:0]              e_op;
  logic                    e_lvl;
  logic [3:0]              bit_sel;

  assign last_beat = (beat_q == 2'd3);
  assign pop_o     = ev_valid_i && (!busy_q || (ack_o.ready && last_beat));
  assign el_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    lev_d     = lev_q;
    elapsed_d = elapsed_q;
    emit      = 1'b0;
    e_op      = ev_i.op;
    e_lvl     = ev_i.on;
    bit_sel   = '0;

    if (pop_o) begin
      if (ev_i.kind == icsq_pkg::EV_TICK) begin
        elapsed_d = el_inc;
        case (phase_q)
          icsq_pkg::PH_FIRING: begin
            if (CmpW'(el_inc) >= CmpW'(pilot_delay_i)) begin
              lev_d[icsq_pkg::LvPilot] = 1'b1;
              phase_d = icsq_pkg::PH_PILOT;
              emit    = 1'b1;
              e_op    = icsq_pkg::OpPilot;
              e_lvl   = 1'b1;
            end
          end
          icsq_pkg::PH_PILOT: begin
            if (CmpW'(el_inc) > CmpW'(burn_time_i)) begin
              lev_d[icsq_pkg::LvIgn] = 1'b0;
              phase_d = icsq_pkg::PH_DONE;
              emit    = 1'b1;
              e_op    = icsq_pkg::OpIgn;
              e_lvl   = 1'b0;
            end
          end
          icsq_pkg::PH_DONE: begin
            phase_d = icsq_pkg::PH_IDLE;
          end
          default: begin
          end
        endcase
      end else begin
        emit = 1'b1;
        if (ev_i.op == icsq_pkg::OpIgn) begin
          if (ev_i.on) begin
            lev_d[icsq_pkg::LvIgn] = 1'b1;
            phase_d   = icsq_pkg::PH_FIRING;
            elapsed_d = '0;
          end else begin
            lev_d[icsq_pkg::LvIgn]   = 1'b0;
            lev_d[icsq_pkg::LvPilot] = 1'b0;
            phase_d = icsq_pkg::PH_IDLE;
          end
        end else begin
          // front end only passes known ops, so one of these is set
          bit_sel[icsq_pkg::LvPilot] = (ev_i.op == icsq_pkg::OpPilot);
          bit_sel[icsq_pkg::LvTanks] = (ev_i.op == icsq_pkg::OpTanks);
          bit_sel[icsq_pkg::LvSpare] = (ev_i.op == icsq_pkg::OpSpare);
          lev_d = ev_i.on ? (lev_q | bit_sel) : (lev_q & ~bit_sel);
        end
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    aop_d  = aop_q;
    alvl_d = alvl_q;
    if (busy_q && ack_o.ready) begin
      beat_d = beat_q + 1'b1;
      if (last_beat) begin
        busy_d = 1'b0;
      end
    end
    if (emit) begin
      busy_d = 1'b1;
      beat_d = '0;
      aop_d  = e_op;
      alvl_d = e_lvl;
    end
  end

  always_comb begin
    case (beat_q)
      2'd0:    ack_o.ack_byte = icsq_pkg::AckHdr;
      2'd1:    ack_o.ack_byte = aop_q;
      2'd2:    ack_o.ack_byte = {7'd0, alvl_q};
      default: ack_o.ack_byte = icsq_pkg::AckHdr ^ aop_q ^ {7'd0, alvl_q};
    endcase
  end

  assign ack_o.valid      = busy_q;
  assign ack_o.ack_last   = last_beat;
  assign ack_o.igniter_on = lev_q[icsq_pkg::LvIgn];
  assign ack_o.pilot_on   = lev_q[icsq_pkg::LvPilot];
  assign ack_o.tanks_on   = lev_q[icsq_pkg::LvTanks];
  assign ack_o.spare_on   = lev_q[icsq_pkg::LvSpare];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= icsq_pkg::PH_IDLE;
      lev_q     <= '0;
      elapsed_q <= '0;
      busy_q    <= 1'b0;
      beat_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      lev_q     <= lev_d;
      elapsed_q <= elapsed_d;
      busy_q    <= busy_d;
      beat_q    <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aop_q  <= aop_d;
    alvl_q <= alvl_d;
  end

endmodule

// ----- src/igniter_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// igniter_command_sequencer
// Command frame receiver and timed igniter/pilot sequencer with acknowledges.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | transfer
//  req_i   | in  | req_type, rx_byte                              | valid & ready
//  ack_o   | out | ack_byte, ack_last, igniter/pilot/tanks/spare  | valid & ready
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i               | cfg_we_i
//
// An item that causes no acknowledge leaves the back end free for the next;
// one with an acknowledge holds the next until its four frame beats are taken.
// A two-entry event queue lets requests keep flowing while a frame drains.
// Reset is asynchronous and takes effect at once; no clearing pass.
// Output stalls back up into the queue, then into req_i.ready.
// ----------------------------------------------------------------------------
module igniter_command_sequencer #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  icsq_req_if.sink                  req_i,
  icsq_ack_if.source                ack_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [icsq_pkg::CfgW-1:0] cfg_wdata_i
);

  logic [icsq_pkg::CfgW-1:0] pilot_delay_q;
  logic [icsq_pkg::CfgW-1:0] burn_time_q;
  logic                      q_full;
  logic                      push;
  logic                      q_valid;
  logic                      pop;
  icsq_pkg::event_t          ev_in;
  icsq_pkg::event_t          ev_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pilot_delay_q <= icsq_pkg::PilotDelayRst;
      burn_time_q   <= icsq_pkg::BurnTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        icsq_pkg::RegPilotDelay: pilot_delay_q <= cfg_wdata_i;
        icsq_pkg::RegBurnTime:   burn_time_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  icsq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .ev_o     (ev_in)
  );

  icsq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ev_i    (ev_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .ev_o    (ev_out)
  );

  icsq_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (q_valid),
    .ev_i          (ev_out),
    .pop_o         (pop),
    .pilot_delay_i (pilot_delay_q),
    .burn_time_i   (burn_time_q),
    .ack_o         (ack_o)
  );

endmodule

// ----- src/icsq_checker.sv -----
// ----------------------------------------------------------------------------
// icsq_checker
// Port-level checks on acknowledge frame structure.
// ----------------------------------------------------------------------------
module icsq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       ack_valid_i,
  input logic       ack_ready_i,
  input logic [7:0] ack_byte_i,
  input logic       ack_last_i,
  input logic [3:0] levels_i
);

  logic [1:0] beat_q;
  logic       xfer;

  assign xfer = ack_valid_i && ack_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (xfer) begin
      beat_q <= beat_q + 1'b1;
    end
  end

  a_last_on_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_valid_i |-> (ack_last_i == (beat_q == 2'd3)))
    else $error("ack_last out of step with frame position");

  a_header_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_valid_i && beat_q == 2'd0) |-> (ack_byte_i == icsq_pkg::AckHdr))
    else $error("acknowledge frame does not start with header");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !ack_last_i) |=> (ack_valid_i && $stable(levels_i)))
    else $error("acknowledge frame broken or levels changed mid-frame");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_valid_i && !ack_ready_i) |=> (ack_valid_i && $stable(ack_byte_i)))
    else $error("stalled acknowledge byte changed");

endmodule

bind igniter_command_sequencer icsq_checker u_icsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .ack_valid_i (ack_o.valid),
  .ack_ready_i (ack_o.ready),
  .ack_byte_i  (ack_o.ack_byte),
  .ack_last_i  (ack_o.ack_last),
  .levels_i    ({ack_o.spare_on, ack_o.tanks_on, ack_o.pilot_on, ack_o.igniter_on})
);
